[hw/rtl/rbc_pkg.sv]
// ----------------------------------------------------------------------------
// rbc_pkg: radix base converter shared definitions
// Widths, beat types and digit/character helper functions.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int VALUE_BITS = 64;
    localparam int OUT_DIGITS = 64;

    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 7;
    localparam int RDIG_W  = 4;
    localparam int CNT_W   = $clog2(OUT_DIGITS + 1);
    localparam int ADDR_W  = $clog2(OUT_DIGITS);
    localparam int BIT_W   = $clog2(VALUE_BITS);

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic [BASE_W-1:0] source_base;
        logic [BASE_W-1:0] dest_base;
        logic              last_digit;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              illegal;
        logic              last_out;
    } out_beat_t;

    // char <= '9': char mod 48, else (char mod 65) + 10
    function automatic logic [DIGIT_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        if (c < CHAR_W'(48))
            d = DIGIT_W'(c);
        else if (c <= CHAR_W'(57))
            d = DIGIT_W'(c - CHAR_W'(48));
        else if (c < CHAR_W'(65))
            d = DIGIT_W'(c + CHAR_W'(10));
        else if (c < CHAR_W'(130))
            d = DIGIT_W'(c - CHAR_W'(55));
        else if (c < CHAR_W'(195))
            d = DIGIT_W'(c - CHAR_W'(120));
        else
            d = DIGIT_W'(c - CHAR_W'(185));
        return d;
    endfunction

    function automatic logic [BASE_W-1:0] clamp_radix(input logic [BASE_W-1:0] r);
        logic [BASE_W-1:0] o;
        if (r < BASE_W'(2))
            o = BASE_W'(2);
        else if (r > BASE_W'(16))
            o = BASE_W'(16);
        else
            o = r;
        return o;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RDIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= RDIG_W'(9))
            c = CHAR_W'(d) + CHAR_W'(48);
        else
            c = CHAR_W'(d) + CHAR_W'(55);
        return c;
    endfunction

endpackage

[hw/rtl/rbc_if.sv]
// ----------------------------------------------------------------------------
// rbc_if: radix base converter channel interfaces
// Valid/ready channels for source digit beats and result character beats.
// ----------------------------------------------------------------------------
interface rbc_in_if;
    import rbc_pkg::*;

    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbc_out_if;
    import rbc_pkg::*;

    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rbc_ram.sv]
// ----------------------------------------------------------------------------
// rbc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rbc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/radix_base_converter_top.sv]
// ----------------------------------------------------------------------------
// radix_base_converter_top: ASCII radix base converter
// Accumulates source digits, then emits the value in the target radix.
// ----------------------------------------------------------------------------
// Usage:
//   digits : one beat per source character, most significant first. The
//            radix fields are latched on the first beat of a number;
//            last_digit closes the number.
//   result : one beat per output character, most significant first, with
//            last_out on the final one; a number holding a digit not below
//            the source radix gives a single beat with illegal set.
// Sequence: non-final digit beats are accepted back to back. The final beat
//   starts conversion: the bit-serial restoring divider produces each result
//   digit (one quotient bit per cycle), then each character goes through the
//   digit RAM read port (S_READ, S_LOAD) and waits in S_SEND for the receiver.
//   digits.ready is low from the final beat until the last result beat.
// Reset: clears the sequencer and number state; radices default to 2.
// Stall: a result beat holds in the output register until result.ready.
// ----------------------------------------------------------------------------
module radix_base_converter_top (
    input  logic clk,
    input  logic rst_n,
    rbc_in_if.sink    digits,
    rbc_out_if.source result
);
    import rbc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_LOAD = 5'b01000,
        S_SEND = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [DIGIT_W-1:0]      hd_reg, hd_next;
    logic [BASE_W-1:0]       sb_reg, sb_next;
    logic [BASE_W-1:0]       db_reg, db_next;
    logic                    in_num_reg, in_num_next;
    logic [VALUE_BITS-1:0]   div_reg, div_next;
    logic [RDIG_W-1:0]       rem_reg, rem_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    out_beat_t               out_data_reg, out_data_next;

    logic                    in_fire;
    logic [BASE_W-1:0]       sb_eff;
    logic [DIGIT_W-1:0]      dig;
    logic [DIGIT_W-1:0]      hd_new;
    logic [VALUE_BITS-1:0]   acc_base;
    logic [VALUE_BITS-1:0]   acc_new;
    logic [BASE_W-1:0]       trial;
    logic                    ge;
    logic [BASE_W-1:0]       trial_sub;
    logic [RDIG_W-1:0]       rem_step;
    logic [VALUE_BITS-1:0]   div_step;
    logic                    ram_we;
    logic [RDIG_W-1:0]       ram_rdata;

    assign digits.ready = (state_reg == S_IDLE);
    assign in_fire      = digits.valid && digits.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // accumulate datapath
    assign sb_eff   = in_num_reg ? sb_reg : clamp_radix(digits.data.source_base);
    assign dig      = decode_char(digits.data.digit_char);
    assign hd_new   = (in_num_reg && (hd_reg > dig)) ? hd_reg : dig;
    assign acc_base = in_num_reg ? acc_reg : '0;
    assign acc_new  = VALUE_BITS'(acc_base * sb_eff) + VALUE_BITS'(dig);

    // restoring divide step, one quotient bit
    assign trial     = {rem_reg, div_reg[VALUE_BITS-1]};
    assign ge        = (trial >= db_reg);
    assign trial_sub = ge ? (trial - db_reg) : trial;
    assign rem_step  = trial_sub[RDIG_W-1:0];
    assign div_step  = {div_reg[VALUE_BITS-2:0], ge};

    assign ram_we = (state_reg == S_DIV) && (bit_reg == BIT_W'(VALUE_BITS - 1));

    rbc_ram #(
        .WIDTH (RDIG_W),
        .DEPTH (OUT_DIGITS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (rem_step),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        hd_next        = hd_reg;
        sb_next        = sb_reg;
        db_next        = db_reg;
        in_num_next    = in_num_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!in_num_reg)
                    begin
                        sb_next = sb_eff;
                        db_next = clamp_radix(digits.data.dest_base);
                    end
                    if (!digits.data.last_digit)
                    begin
                        in_num_next = 1'b1;
                        acc_next    = acc_new;
                        hd_next     = hd_new;
                    end
                    else
                    begin
                        in_num_next = 1'b0;
                        acc_next    = '0;
                        hd_next     = '0;
                        if (hd_new >= DIGIT_W'(sb_eff))
                        begin
                            out_data_next  = '{out_char: '0, illegal: 1'b1, last_out: 1'b1};
                            out_valid_next = 1'b1;
                            state_next     = S_SEND;
                        end
                        else
                        begin
                            div_next   = acc_new;
                            rem_next   = '0;
                            bit_next   = '0;
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                div_next = div_step;
                rem_next = rem_step;
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(VALUE_BITS - 1))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    rem_next = '0;
                    bit_next = '0;
                    if ((div_step != '0) && (cnt_reg < CNT_W'(OUT_DIGITS - 1)))
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        idx_next   = cnt_reg[ADDR_W-1:0];
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                out_data_next  = '{out_char: digit_to_char(ram_rdata),
                                   illegal:  1'b0,
                                   last_out: (idx_reg == '0)};
                out_valid_next = 1'b1;
                state_next     = S_SEND;
            end
            S_SEND:
            begin
                if (result.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_data_reg.last_out)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            hd_reg        <= '0;
            sb_reg        <= BASE_W'(2);
            db_reg        <= BASE_W'(2);
            in_num_reg    <= 1'b0;
            bit_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            hd_reg        <= hd_next;
            sb_reg        <= sb_next;
            db_reg        <= db_next;
            in_num_reg    <= in_num_next;
            bit_reg       <= bit_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

endmodule

[verif/rbc_conversion_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbc_conversion_checker: result prediction and comparison
// Watches both channels. Each accepted digit beat updates a private copy of
// the number state. A closing beat queues the expected characters, or one
// illegal beat. Each result beat is compared with the oldest queued entry.
// ----------------------------------------------------------------------------
module rbc_conversion_checker (
    input  logic clk,
    input  logic rst_n,
    rbc_in_if    digits,
    rbc_out_if   result,
    output int   mismatches,
    output int   outstanding
);
    import rbc_pkg::*;

    localparam int CH_NINE       = 57;
    localparam int CH_ZERO       = 48;
    localparam int CH_UPPER_A    = 65;
    localparam int LETTER_DIGIT  = 10;
    localparam int LAST_NUMERIC  = 9;
    localparam int CH_ALPHA_BIAS = 55;
    localparam int REPORT_LIMIT  = 10;

    logic [VALUE_BITS-1:0] acc_value;
    logic [DIGIT_W-1:0]    top_digit;
    logic [BASE_W-1:0]     src_radix;
    logic [BASE_W-1:0]     dst_radix;
    logic                  mid_number;
    out_beat_t             expected_chars[$];
    int                    bad_beats;

    assign mismatches = bad_beats;

    function automatic logic [BASE_W-1:0] bounded_radix(input logic [BASE_W-1:0] r);
        logic [BASE_W-1:0] o;
        o = r;
        if (r < BASE_W'(2))
            o = BASE_W'(2);
        else if (r > BASE_W'(16))
            o = BASE_W'(16);
        return o;
    endfunction

    function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        int v;
        if (c <= CH_NINE)
            v = c % CH_ZERO;
        else
            v = c % CH_UPPER_A + LETTER_DIGIT;
        return DIGIT_W'(v);
    endfunction

    task automatic queue_conversion();
        logic [RDIG_W-1:0]     digs[OUT_DIGITS];
        logic [VALUE_BITS-1:0] v;
        logic [RDIG_W-1:0]     dig;
        out_beat_t             beat;
        int                    n;
        if (top_digit >= src_radix)
        begin
            beat.out_char = '0;
            beat.illegal  = 1'b1;
            beat.last_out = 1'b1;
            expected_chars.push_back(beat);
        end
        else
        begin
            v = acc_value;
            n = 0;
            do
            begin
                digs[n] = RDIG_W'(v % dst_radix);
                v = v / dst_radix;
                n++;
            end
            while (v != 0 && n < OUT_DIGITS);
            for (int k = 0; k < n; k++)
            begin
                dig = digs[n - 1 - k];
                beat.out_char = (dig <= LAST_NUMERIC) ? CHAR_W'(dig + CH_ZERO)
                                                      : CHAR_W'(dig + CH_ALPHA_BIAS);
                beat.illegal  = 1'b0;
                beat.last_out = (k == n - 1);
                expected_chars.push_back(beat);
            end
        end
        acc_value = '0;
        top_digit = '0;
    endtask

    task automatic fold_digit(input in_beat_t b);
        logic [DIGIT_W-1:0] d;
        if (!mid_number)
        begin
            src_radix  = bounded_radix(b.source_base);
            dst_radix  = bounded_radix(b.dest_base);
            acc_value  = '0;
            top_digit  = '0;
            mid_number = 1'b1;
        end
        d = char_value(b.digit_char);
        if (d > top_digit)
            top_digit = d;
        acc_value = acc_value * src_radix + d;
        if (b.last_digit)
        begin
            mid_number = 1'b0;
            queue_conversion();
        end
    endtask

    task automatic compare_char(input out_beat_t got);
        out_beat_t want;
        if (expected_chars.size() == 0)
        begin
            bad_beats++;
            if (bad_beats <= REPORT_LIMIT)
                $display("%0t: unexpected result beat char %0d illegal %0b last %0b",
                         $time, got.out_char, got.illegal, got.last_out);
        end
        else
        begin
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char || got.illegal !== want.illegal
                || got.last_out !== want.last_out)
            begin
                bad_beats++;
                if (bad_beats <= REPORT_LIMIT)
                    $display({"%0t: result mismatch: expected char %0d illegal %0b last %0b,",
                              " got char %0d illegal %0b last %0b"}, $time,
                             want.out_char, want.illegal, want.last_out,
                             got.out_char, got.illegal, got.last_out);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_value  = '0;
            top_digit  = '0;
            src_radix  = BASE_W'(2);
            dst_radix  = BASE_W'(2);
            mid_number = 1'b0;
            expected_chars.delete();
            bad_beats  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (digits.valid && digits.ready)
                fold_digit(digits.data);
            if (result.valid && result.ready)
                compare_char(result.data);
            outstanding <= expected_chars.size();
        end
    end

endmodule

[verif/tb_radix_base_converter_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_base_converter_top: radix base converter testbench
// Drives digit beats (directed corner numbers, then random numbers with
// random radices, odd characters and long wrapping values) under random
// valid gaps and result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_radix_base_converter_top;
    import rbc_pkg::*;

    localparam int BEAT_TARGET   = 430;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CH_ZERO       = 48;
    localparam int CH_ALPHA_BIAS = 55;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   outstanding;
    int   beats_sent = 0;
    int   cycles     = 0;
    bit   feed_calm  = 1'b0;
    bit   drain_calm = 1'b0;

    rbc_in_if  digits();
    rbc_out_if result();

    radix_base_converter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .digits (digits),
        .result (result)
    );

    rbc_conversion_checker conv_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .digits      (digits),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("radix_base_converter_top verification failed");
            $finish;
        end
    end

    task automatic send_digit(input logic [CHAR_W-1:0] ch, input logic [BASE_W-1:0] sb,
                              input logic [BASE_W-1:0] db, input logic last);
        int gap;
        if ($urandom_range(0, 24) == 0)
            feed_calm = !feed_calm;
        gap = feed_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            digits.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        digits.valid <= 1'b1;
        digits.data  <= {ch, sb, db, last};
        @(posedge clk);
        while (!digits.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s, input logic [BASE_W-1:0] sb,
                             input logic [BASE_W-1:0] db);
        for (int i = 0; i < s.len(); i++)
            send_digit(s[i], (i == 0) ? sb : BASE_W'($urandom_range(0, 31)),
                       (i == 0) ? db : BASE_W'($urandom_range(0, 31)), i == s.len() - 1);
    endtask

    task automatic send_random_number();
        logic [BASE_W-1:0] sb_raw;
        logic [BASE_W-1:0] db_raw;
        logic [CHAR_W-1:0] ch;
        int                radix;
        int                len;
        int                d;
        sb_raw = ($urandom_range(0, 9) == 0) ? BASE_W'($urandom_range(0, 31))
                                             : BASE_W'($urandom_range(2, 16));
        db_raw = ($urandom_range(0, 9) == 0) ? BASE_W'($urandom_range(0, 31))
                                             : BASE_W'($urandom_range(2, 16));
        radix  = (sb_raw < 2) ? 2 : (sb_raw > 16) ? 16 : sb_raw;
        len    = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            d  = $urandom_range(0, radix - 1);
            ch = (d <= 9) ? CHAR_W'(d + CH_ZERO) : CHAR_W'(d + CH_ALPHA_BIAS);
            if ($urandom_range(0, 29) == 0)
                ch = CHAR_W'($urandom_range(0, 255));
            send_digit(ch, (i == 0) ? sb_raw : BASE_W'($urandom_range(0, 31)),
                       (i == 0) ? db_raw : BASE_W'($urandom_range(0, 31)), i == len - 1);
        end
    endtask

    initial
    begin : result_drain
        int stall;
        result.ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                drain_calm = !drain_calm;
            stall = drain_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        digits.valid <= 1'b0;
        digits.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // radices below and above range clamp to 2 and 16
        send_text("101", 5'd0, 5'd31);
        // full 64-bit value, longest binary result
        send_text("FFFFFFFFFFFFFFFF", 5'd16, 5'd2);
        send_text("FF", 5'd16, 5'd16);
        send_text("2", 5'd2, 5'd10);
        send_text("@", 5'd16, 5'd16);
        send_digit(8'd255, 5'd16, 5'd16, 1'b1);
        send_digit(8'd0, 5'd16, 5'd16, 1'b1);

        while (beats_sent < BEAT_TARGET)
            send_random_number();
        digits.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("radix_base_converter_top verification clean");
        else
            $display("radix_base_converter_top verification failed");
        $finish;
    end

endmodule
